// File: rtl/hbcd_pkg.sv
// ----------------------------------------------------------------------------
// hbcd_pkg: shared types and constants of the chunked body deframer
// status codes, parse phases, register indexes, result item layout
// ----------------------------------------------------------------------------
package hbcd_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_MORE  = 3'd0,
    ST_DONE  = 3'd1,
    ST_LONG  = 3'd2,
    ST_BIG   = 3'd3,
    ST_AFTER = 3'd4
  } status_e;

  // parse phases
  typedef enum logic [1:0] {
    PH_SIZE = 2'd0,
    PH_DATA = 2'd1,
    PH_SKIP = 2'd2,
    PH_TAIL = 2'd3
  } phase_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_CHUNKED_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CONTENT_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_CHUNK_SIZE = 2'd2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    status_e    status;
  } result_t;

  // hex digit decode: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: rtl/hbcd_if.sv
// ----------------------------------------------------------------------------
// hbcd channel interfaces
// valid/ready channels for raw body bytes and for decoded result items
// ----------------------------------------------------------------------------
interface hbcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       first_byte;

  modport source (output valid, output body_byte, output first_byte, input ready);
  modport sink   (input valid, input body_byte, input first_byte, output ready);
endinterface

interface hbcd_out_if;
  logic               valid;
  logic               ready;
  logic               payload_valid;
  logic [7:0]         payload_byte;
  hbcd_pkg::status_e  status;

  modport source (output valid, output payload_valid, output payload_byte,
                  output status, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input status, output ready);
endinterface

// File: rtl/http_body_chunked_deframer.sv
// ----------------------------------------------------------------------------
// http_body_chunked_deframer
// byte-wise http body decoder for fixed content length and chunked framing
// ----------------------------------------------------------------------------
// Takes one body byte per clock while input ready is high and returns exactly
// one result item per byte: an optional payload byte and a status (more data,
// complete, size line too long, chunk size too big, ignored after end). Each
// accepted byte updates the parse state in the same cycle and its result is
// registered, so sustained throughput is one byte every clock. Results sit in
// an output register backed by a one-entry skid register; input ready drops
// only while both hold results the sink has not yet taken. Chunk sizes are
// parsed as hex up to the first non-hex character of the size line, limited
// to MAX_SIZE_DIGITS characters per line. Configuration writes are taken on
// any cycle with cfg_we_i high and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module http_body_chunked_deframer #(
  parameter int unsigned MAX_SIZE_DIGITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hbcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hbcd_pkg::CfgDataW-1:0] cfg_data_i,
  hbcd_in_if.sink                       in_i,
  hbcd_out_if.source                    res_o
);

  // chunk size register holds at most MAX_SIZE_DIGITS hex digits
  localparam int unsigned LenW = 4 * MAX_SIZE_DIGITS;
  localparam int unsigned CmpW = (LenW > 32) ? LenW : 32;
  // line char count reaches MAX_SIZE_DIGITS + 1 on overflow
  localparam int unsigned LcW  = $clog2(MAX_SIZE_DIGITS + 2);

  // configuration
  logic        chunked_q;
  logic [31:0] content_len_q;
  logic [31:0] max_chunk_q;

  // parse state
  hbcd_pkg::phase_e  phase_q, phase_d;
  logic [LenW-1:0]   len_q, len_d;        // chunk size being parsed
  logic [31:0]       left_q, left_d;      // data bytes left in the chunk
  logic [31:0]       body_q, body_d;      // payload bytes delivered
  logic [LcW-1:0]    lc_q, lc_d;          // size line characters
  logic              hex_end_q, hex_end_d;
  logic              saw_cr_q, saw_cr_d;
  logic [1:0]        skip_q, skip_d;
  hbcd_pkg::status_e final_q, final_d;    // sticky end or error code

  // result registers
  hbcd_pkg::result_t out_q, skid_q, res_d;
  logic              out_valid_q, skid_valid_q;

  logic       in_fire, out_fire;
  logic [7:0] c;
  logic [4:0] hex;
  logic       go_on;
  logic       body_lt;

  assign c        = in_i.body_byte;
  assign hex      = hbcd_pkg::hex_decode(c);
  assign in_i.ready = !skid_valid_q;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && res_o.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunked_q     <= 1'b0;
      content_len_q <= 32'd0;
      max_chunk_q   <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hbcd_pkg::CFG_CHUNKED_MODE:   chunked_q     <= cfg_data_i[0];
        hbcd_pkg::CFG_CONTENT_LENGTH: content_len_q <= cfg_data_i;
        hbcd_pkg::CFG_MAX_CHUNK_SIZE: max_chunk_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // one byte of parsing
  always_comb begin
    // first_byte clears all parse state ahead of this byte
    if (in_i.first_byte) begin
      phase_d   = hbcd_pkg::PH_SIZE;
      len_d     = '0;
      left_d    = '0;
      body_d    = '0;
      lc_d      = '0;
      hex_end_d = 1'b0;
      saw_cr_d  = 1'b0;
      skip_d    = 2'd0;
      final_d   = hbcd_pkg::ST_MORE;
    end else begin
      phase_d   = phase_q;
      len_d     = len_q;
      left_d    = left_q;
      body_d    = body_q;
      lc_d      = lc_q;
      hex_end_d = hex_end_q;
      saw_cr_d  = saw_cr_q;
      skip_d    = skip_q;
      final_d   = final_q;
    end

    res_d.payload_valid = 1'b0;
    res_d.payload_byte  = 8'd0;
    res_d.status        = hbcd_pkg::ST_MORE;
    go_on   = 1'b1;
    body_lt = body_d < content_len_q;

    if (final_d == hbcd_pkg::ST_DONE) begin
      res_d.status = hbcd_pkg::ST_AFTER;
    end else if (final_d != hbcd_pkg::ST_MORE) begin
      // sticky error repeats
      res_d.status = final_d;
    end else if (!chunked_q) begin
      // plain mode: pass content_length bytes
      if (body_lt) begin
        res_d.payload_valid = 1'b1;
        res_d.payload_byte  = c;
        body_d = body_d + 32'd1;
      end
      if (!body_lt || body_d == content_len_q) begin
        final_d      = hbcd_pkg::ST_DONE;
        res_d.status = hbcd_pkg::ST_DONE;
      end
    end else begin
      case (phase_d)
        hbcd_pkg::PH_DATA: begin
          res_d.payload_valid = 1'b1;
          res_d.payload_byte  = c;
          body_d = body_d + 32'd1;
          left_d = left_d - 32'd1;
          if (left_d == 32'd0) begin
            phase_d = hbcd_pkg::PH_SKIP;
            skip_d  = 2'd2;
          end
        end
        hbcd_pkg::PH_SKIP, hbcd_pkg::PH_TAIL: begin
          if (skip_d != 2'd0) begin
            skip_d = skip_d - 2'd1;
          end
          if (skip_d == 2'd0) begin
            if (phase_d == hbcd_pkg::PH_TAIL) begin
              final_d      = hbcd_pkg::ST_DONE;
              res_d.status = hbcd_pkg::ST_DONE;
            end else begin
              phase_d   = hbcd_pkg::PH_SIZE;
              len_d     = '0;
              left_d    = '0;
              lc_d      = '0;
              hex_end_d = 1'b0;
              saw_cr_d  = 1'b0;
            end
          end
        end
        default: begin
          // size line
          if (saw_cr_d) begin
            saw_cr_d = 1'b0;
            if (c == hbcd_pkg::CHAR_LF) begin
              go_on = 1'b0;
              if (lc_d == '0) begin
                // empty line is skipped
                phase_d   = hbcd_pkg::PH_SIZE;
                len_d     = '0;
                left_d    = '0;
                hex_end_d = 1'b0;
              end else if (CmpW'(len_d) > CmpW'(max_chunk_q)) begin
                final_d      = hbcd_pkg::ST_BIG;
                res_d.status = hbcd_pkg::ST_BIG;
              end else begin
                lc_d      = '0;
                hex_end_d = 1'b0;
                left_d    = 32'(len_d);
                if (len_d == '0) begin
                  phase_d = hbcd_pkg::PH_TAIL;
                  skip_d  = 2'd2;
                end else begin
                  phase_d = hbcd_pkg::PH_DATA;
                end
              end
            end else begin
              // lone cr counts as a line character
              lc_d = lc_d + LcW'(1);
              if (lc_d > LcW'(MAX_SIZE_DIGITS)) begin
                go_on        = 1'b0;
                final_d      = hbcd_pkg::ST_LONG;
                res_d.status = hbcd_pkg::ST_LONG;
              end
            end
          end
          if (go_on) begin
            if (c == hbcd_pkg::CHAR_CR) begin
              saw_cr_d  = 1'b1;
              hex_end_d = 1'b1;
            end else begin
              lc_d = lc_d + LcW'(1);
              if (lc_d > LcW'(MAX_SIZE_DIGITS)) begin
                final_d      = hbcd_pkg::ST_LONG;
                res_d.status = hbcd_pkg::ST_LONG;
              end else if (!hex_end_d) begin
                if (hex[4]) begin
                  len_d = (len_d << 4) | LenW'(hex[3:0]);
                end else begin
                  // extensions after the digits are ignored
                  hex_end_d = 1'b1;
                end
              end
            end
          end
        end
      endcase
    end
  end

  // parse state, updated once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= hbcd_pkg::PH_SIZE;
      len_q     <= '0;
      left_q    <= '0;
      body_q    <= '0;
      lc_q      <= '0;
      hex_end_q <= 1'b0;
      saw_cr_q  <= 1'b0;
      skip_q    <= 2'd0;
      final_q   <= hbcd_pkg::ST_MORE;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      left_q    <= left_d;
      body_q    <= body_d;
      lc_q      <= lc_d;
      hex_end_q <= hex_end_d;
      saw_cr_q  <= saw_cr_d;
      skip_q    <= skip_d;
      final_q   <= final_d;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.payload_valid = out_q.payload_valid;
  assign res_o.payload_byte  = out_q.payload_byte;
  assign res_o.status        = out_q.status;

`ifndef NO_ASSERTIONS
  // the skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without output entry");

  // a chunk in the data phase always has bytes left
  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hbcd_pkg::PH_DATA) |-> (left_q != 32'd0))
    else $error("data phase with no bytes left");

  // line character count never runs past the overflow point
  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lc_q <= LcW'(MAX_SIZE_DIGITS + 1))
    else $error("size line count out of range");

  // payload bytes only travel with more-data or complete status
  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.payload_valid) |->
      (out_q.status == hbcd_pkg::ST_MORE || out_q.status == hbcd_pkg::ST_DONE))
    else $error("payload byte with error status");
`endif

endmodule
